[rtl/core/rational_arithmetic_unit_macros.svh]
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared property macros for the checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rau check failed");

`endif

[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Request/response types, operation and status codes, helpers.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam logic [3:0] KIND_NORM = 4'd0;
	localparam logic [3:0] KIND_ADD  = 4'd1;
	localparam logic [3:0] KIND_SUB  = 4'd2;
	localparam logic [3:0] KIND_MUL  = 4'd3;
	localparam logic [3:0] KIND_DIV  = 4'd4;
	localparam logic [3:0] KIND_EQ   = 4'd5;
	localparam logic [3:0] KIND_LT   = 4'd6;
	localparam logic [3:0] KIND_LE   = 4'd7;
	localparam logic [3:0] KIND_GT   = 4'd8;
	localparam logic [3:0] KIND_GE   = 4'd9;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               cmp_true;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic        nop;
		logic        zden;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} entry_t;

	function automatic logic [32:0] abs32(input logic [31:0] x);
		logic [32:0] e;
		e = {x[31], x};
		return x[31] ? 33'(-e) : e;
	endfunction

endpackage

[rtl/core/rau_front.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts requests, flags unused kinds and zero denominators, queues them.
// ----------------------------------------------------------------------------
module rau_front (
	input  logic            req_valid,
	output logic            req_stall,
	input  rau_pkg::req_t   req,
	input  logic            full,
	output logic            push,
	output rau_pkg::entry_t push_data
);

	logic use_b;

	assign use_b     = (req.kind >= rau_pkg::KIND_ADD) && (req.kind <= rau_pkg::KIND_GE);
	assign req_stall = full;
	assign push      = req_valid && !full;

	always_comb begin
		push_data.kind  = req.kind;
		push_data.nop   = req.kind > rau_pkg::KIND_GE;
		push_data.zden  = (req.a_den == 32'sd0) || (use_b && (req.b_den == 32'sd0));
		push_data.a_num = req.a_num;
		push_data.a_den = req.a_den;
		push_data.b_num = req.b_num;
		push_data.b_den = req.b_den;
	end

endmodule

[rtl/core/rau_fifo.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit request queue
// Short queue between front end and execution core.
// ----------------------------------------------------------------------------
module rau_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rau_pkg::entry_t push_data,
	input  logic            pop,
	output rau_pkg::entry_t head,
	output logic            empty,
	output logic            full
);

	localparam int PW = (rau_pkg::QDEPTH > 1) ? $clog2(rau_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(rau_pkg::QDEPTH + 1);

	rau_pkg::entry_t mem_q [rau_pkg::QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = cnt_q == CW'(0);
	assign full  = cnt_q == CW'(rau_pkg::QDEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(rau_pkg::QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(rau_pkg::QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/core/rau_reduce.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit fraction reducer
// Binary gcd, then one-bit-per-cycle exact division of both terms by it.
// ----------------------------------------------------------------------------
module rau_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n_mag,
	input  logic [63:0] d_mag,
	output logic        done,
	output logic [63:0] q_num,
	output logic [63:0] q_den
);

	typedef enum logic [1:0] {R_IDLE, R_TWOS, R_GCD, R_DIV} rstate_t;

	rstate_t     state_q;
	logic [63:0] x_q, y_q, g_q, num_q, den_q;
	logic [63:0] remn_q, remd_q;
	logic [5:0]  k_q, cnt_q;
	logic        done_q;
	logic [64:0] tn, td;

	assign done  = done_q;
	assign q_num = num_q;
	assign q_den = den_q;

	always_comb begin
		tn = {remn_q, num_q[63]};
		td = {remd_q, den_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			x_q <= '0; y_q <= '0; g_q <= '0; num_q <= '0; den_q <= '0;
			remn_q <= '0; remd_q <= '0; k_q <= '0; cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						if (n_mag == 64'd0) begin
							num_q  <= 64'd0;
							den_q  <= 64'd1;
							done_q <= 1'b1;
						end else begin
							x_q     <= n_mag;
							y_q     <= d_mag;
							num_q   <= n_mag;
							den_q   <= d_mag;
							k_q     <= '0;
							state_q <= R_TWOS;
						end
					end
				end
				R_TWOS: begin
					if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 6'd1;
					end else begin
						state_q <= R_GCD;
					end
				end
				R_GCD: begin
					priority if (x_q == 64'd0) begin
						g_q     <= y_q << k_q;
						remn_q  <= '0;
						remd_q  <= '0;
						cnt_q   <= '0;
						state_q <= R_DIV;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q >= y_q) begin
						x_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
				R_DIV: begin
					if (tn >= {1'b0, g_q}) begin
						remn_q <= 64'(tn - {1'b0, g_q});
						num_q  <= {num_q[62:0], 1'b1};
					end else begin
						remn_q <= tn[63:0];
						num_q  <= {num_q[62:0], 1'b0};
					end
					if (td >= {1'b0, g_q}) begin
						remd_q <= 64'(td - {1'b0, g_q});
						den_q  <= {den_q[62:0], 1'b1};
					end else begin
						remd_q <= td[63:0];
						den_q  <= {den_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/rau_core.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit execution core
// Sequences operand reduction, cross products and result reduction.
// ----------------------------------------------------------------------------
module rau_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  rau_pkg::entry_t head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rau_pkg::rsp_t   rsp
);

	localparam logic [63:0] LIM = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

	typedef enum logic [2:0] {
		C_IDLE, C_RA, C_RB, C_MUL, C_COMB, C_RS, C_RR, C_DONE
	} cstate_t;

	cstate_t      state_q;
	logic [3:0]   kind_q;
	logic [31:0]  bn_q, bd_q;
	logic         sx_q, sy_q, rneg_q, dneg_q;
	logic [31:0]  xn_q, xd_q, yn_q, yd_q;
	logic [1:0]   cnt_q;
	logic [63:0]  prod_q, dmag_q;
	logic signed [63:0] s0_q, s1_q, n_q, nsum;
	logic [31:0]  ma, mb;
	logic         red_start_q, red_done;
	logic [63:0]  red_n_q, red_d_q, red_qn, red_qd;
	logic         red_over, is_cmp, cmp_bit;
	rau_pkg::rsp_t rsp_q;
	logic         rsp_valid_q;
	logic [32:0]  an_m, ad_m, bn_m, bd_m;

	rau_reduce u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start_q),
		.n_mag  (red_n_q),
		.d_mag  (red_d_q),
		.done   (red_done),
		.q_num  (red_qn),
		.q_den  (red_qd)
	);

	assign pop       = (state_q == C_IDLE) && !empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign red_over  = (red_qn > LIM) || (red_qd > LIM);
	assign is_cmp    = kind_q >= rau_pkg::KIND_EQ;

	always_comb begin
		an_m = rau_pkg::abs32(head.a_num);
		ad_m = rau_pkg::abs32(head.a_den);
		bn_m = rau_pkg::abs32(bn_q);
		bd_m = rau_pkg::abs32(bd_q);
	end

	always_comb begin
		unique case (cnt_q)
			2'd0: begin
				ma = xn_q;
				mb = (kind_q == rau_pkg::KIND_MUL) ? yn_q : yd_q;
			end
			2'd1: begin
				ma = yn_q;
				mb = xd_q;
			end
			default: begin
				ma = xd_q;
				mb = (kind_q == rau_pkg::KIND_DIV) ? yn_q : yd_q;
			end
		endcase
	end

	always_comb begin
		priority if (kind_q == rau_pkg::KIND_ADD) begin
			nsum = s0_q + s1_q;
		end else if (kind_q == rau_pkg::KIND_SUB || is_cmp) begin
			nsum = s0_q - s1_q;
		end else begin
			nsum = s0_q;
		end
	end

	always_comb begin
		unique case (kind_q)
			rau_pkg::KIND_EQ: cmp_bit = nsum == 64'sd0;
			rau_pkg::KIND_LT: cmp_bit = nsum < 64'sd0;
			rau_pkg::KIND_LE: cmp_bit = nsum <= 64'sd0;
			rau_pkg::KIND_GT: cmp_bit = nsum > 64'sd0;
			default:          cmp_bit = nsum >= 64'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == C_MUL) begin
			prod_q <= ma * mb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			rsp_valid_q <= 1'b0;
			red_start_q <= 1'b0;
			rsp_q       <= '0;
			kind_q <= '0; bn_q <= '0; bd_q <= '0;
			sx_q <= 1'b0; sy_q <= 1'b0; rneg_q <= 1'b0; dneg_q <= 1'b0;
			xn_q <= '0; xd_q <= '0; yn_q <= '0; yd_q <= '0;
			cnt_q <= '0; dmag_q <= '0; s0_q <= '0; s1_q <= '0; n_q <= '0;
			red_n_q <= '0; red_d_q <= '0;
		end else begin
			red_start_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (!empty) begin
						kind_q <= head.kind;
						bn_q   <= head.b_num;
						bd_q   <= head.b_den;
						rsp_q  <= '{res_num: 32'sd0, res_den: 31'd1, cmp_true: 1'b0,
							status: (head.zden && !head.nop) ? rau_pkg::ST_ZERO_DEN
								: rau_pkg::ST_OK};
						priority if (head.nop || head.zden) begin
							rsp_valid_q <= 1'b1;
							state_q     <= C_DONE;
						end else begin
							sx_q        <= (head.a_num != 32'd0) && (head.a_num[31] ^ head.a_den[31]);
							red_n_q     <= {31'd0, an_m};
							red_d_q     <= {31'd0, ad_m};
							red_start_q <= 1'b1;
							state_q     <= C_RA;
						end
					end
				end
				C_RA: begin
					if (red_done) begin
						priority if (red_over) begin
							rsp_q.status <= rau_pkg::ST_OVERFLOW;
							rsp_valid_q  <= 1'b1;
							state_q      <= C_DONE;
						end else if (kind_q == rau_pkg::KIND_NORM) begin
							rsp_q <= '{res_num: sx_q ? -$signed(red_qn[31:0])
									: $signed(red_qn[31:0]),
								res_den: red_qd[30:0], cmp_true: 1'b0,
								status: rau_pkg::ST_OK};
							rsp_valid_q   <= 1'b1;
							state_q       <= C_DONE;
						end else begin
							xn_q        <= red_qn[31:0];
							xd_q        <= red_qd[31:0];
							sy_q        <= (bn_q != 32'd0) && (bn_q[31] ^ bd_q[31]);
							red_n_q     <= {31'd0, bn_m};
							red_d_q     <= {31'd0, bd_m};
							red_start_q <= 1'b1;
							state_q     <= C_RB;
						end
					end
				end
				C_RB: begin
					if (red_done) begin
						priority if (red_over) begin
							rsp_q.status <= rau_pkg::ST_OVERFLOW;
							rsp_valid_q  <= 1'b1;
							state_q      <= C_DONE;
						end else if (kind_q == rau_pkg::KIND_DIV && red_qn == 64'd0) begin
							rsp_q.status <= rau_pkg::ST_DIV_ZERO;
							rsp_valid_q  <= 1'b1;
							state_q      <= C_DONE;
						end else begin
							yn_q    <= red_qn[31:0];
							yd_q    <= red_qd[31:0];
							cnt_q   <= '0;
							state_q <= C_MUL;
						end
					end
				end
				C_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					unique case (cnt_q)
						2'd1: s0_q <= (sx_q ^ ((kind_q == rau_pkg::KIND_MUL) && sy_q)) ?
							-$signed(prod_q) : $signed(prod_q);
						2'd2: s1_q <= sy_q ? -$signed(prod_q) : $signed(prod_q);
						2'd3: begin
							dmag_q  <= prod_q;
							dneg_q  <= (kind_q == rau_pkg::KIND_DIV) && sy_q;
							state_q <= C_COMB;
						end
						default: ;
					endcase
				end
				C_COMB: begin
					n_q <= nsum;
					if (is_cmp) begin
						rsp_q.cmp_true <= cmp_bit;
						rsp_valid_q    <= 1'b1;
						state_q        <= C_DONE;
					end else begin
						state_q <= C_RS;
					end
				end
				C_RS: begin
					red_n_q     <= n_q[63] ? 64'(-n_q) : 64'(n_q);
					red_d_q     <= dmag_q;
					rneg_q      <= n_q[63] ^ dneg_q;
					red_start_q <= 1'b1;
					state_q     <= C_RR;
				end
				C_RR: begin
					if (red_done) begin
						if (red_over) begin
							rsp_q.status <= rau_pkg::ST_OVERFLOW;
						end else begin
							rsp_q <= '{res_num: rneg_q ? -$signed(red_qn[31:0])
									: $signed(red_qn[31:0]),
								res_den: red_qd[30:0], cmp_true: 1'b0,
								status: rau_pkg::ST_OK};
						end
						rsp_valid_q <= 1'b1;
						state_q     <= C_DONE;
					end
				end
				C_DONE: begin
					if (!rsp_stall) begin
						rsp_valid_q <= 1'b0;
						state_q     <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/rational_arithmetic_unit.sv]
// Each request's time in the core is set by the shared reducer: a binary gcd of
// shift/subtract steps, then a one-bit-per-cycle division, run on each operand
// in use and, for arithmetic kinds, once on the 64-bit result, plus the three
// cross products on one 32x32 multiplier. Requests with a zero denominator or
// an unused kind skip the reducer and the multiplier. Two requests can wait in
// the queue while the core is busy.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Front end, request queue and execution core for reduced-fraction math.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rau_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rau_pkg::rsp_t rsp
);

	logic            push, pop, empty, full;
	rau_pkg::entry_t push_data, head;

	rau_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	rau_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	rau_core #(.VALUE_BITS(VALUE_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[rtl/core/rau_checker.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level properties on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rau_pkg::rsp_t rsp
);

	`RAU_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`RAU_ASSERT_IMP(a_err_zero, clk, arst_n, rsp_valid && (rsp.status != rau_pkg::ST_OK), rsp.res_num == 32'sd0 && rsp.res_den == 31'd1 && !rsp.cmp_true)
	`RAU_ASSERT_IMP(a_cmp_unit, clk, arst_n, rsp_valid && rsp.cmp_true, rsp.res_num == 32'sd0 && rsp.res_den == 31'd1)
	`RAU_ASSERT_IMP(a_den_nz, clk, arst_n, rsp_valid, rsp.res_den != 31'd0)

endmodule

bind rational_arithmetic_unit rau_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
